>>> design/rau_pkg.sv
// Shared types and codes for the rational arithmetic unit.
`default_nettype none

package rau_pkg;

    // Request operation codes
    typedef enum logic [1:0] {
        REQ_MUL  = 2'd0,
        REQ_ADD  = 2'd1,
        REQ_SIMP = 2'd2
    } req_t;

    // Operations of the shared shift-add / shift-subtract unit
    typedef enum logic {
        ALU_MUL = 1'b0,
        ALU_DIV = 1'b1
    } alu_op_t;

    // Command from the sequencer to the shared unit
    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_cmd_t;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL1,
        S_MUL2,
        S_MUL3,
        S_GCD,
        S_DIV1,
        S_DIV2,
        S_OUT
    } state_t;

endpackage

`default_nettype wire

>>> design/rau_alu.sv
// Shared iterative unit: low-half shift-add multiply and restoring divide, one bit per cycle.
`default_nettype none

module rau_alu #(
    parameter int WIDTH = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  rau_pkg::alu_cmd_t    cmd,
    input  logic [WIDTH-1:0]     opx,     // multiplier / dividend
    input  logic [WIDTH-1:0]     opy,     // multiplicand / divisor
    output logic                 done,
    output logic [WIDTH-1:0]     result
);
    import rau_pkg::*;

    localparam int CW = $clog2(WIDTH);

    logic             busy_reg;
    logic             done_reg;
    logic [CW-1:0]    cnt_reg;
    logic             is_div_reg;
    logic [WIDTH-1:0] acc_reg;     // product accumulator / partial remainder
    logic [WIDTH-1:0] dv_reg;      // multiplicand (shifting) / divisor
    logic [WIDTH-1:0] q_reg;       // multiplier (shifting) / dividend -> quotient

    logic [WIDTH:0]   add_a;
    logic [WIDTH:0]   add_b;
    logic [WIDTH:0]   sum;
    logic             last;
    logic             ge;

    // One shared adder: acc + dv for multiply, {rem,bit} - dv for divide
    always_comb begin
        add_a = is_div_reg ? {acc_reg, q_reg[WIDTH-1]} : {1'b0, acc_reg};
        add_b = is_div_reg ? ~{1'b0, dv_reg} : {1'b0, dv_reg};
        sum   = add_a + add_b + {{WIDTH{1'b0}}, is_div_reg};
        ge    = ~sum[WIDTH];
        last  = (cnt_reg == CW'(WIDTH - 1));
    end

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (cmd.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CW'(1);
                if (last) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            is_div_reg <= (cmd.op == ALU_DIV);
            acc_reg    <= '0;
            dv_reg     <= opy;
            q_reg      <= opx;
        end else if (busy_reg) begin
            if (is_div_reg) begin
                acc_reg <= ge ? sum[WIDTH-1:0] : add_a[WIDTH-1:0];
                q_reg   <= {q_reg[WIDTH-2:0], ge};
            end else begin
                if (q_reg[0]) begin
                    acc_reg <= sum[WIDTH-1:0];
                end
                dv_reg <= {dv_reg[WIDTH-2:0], 1'b0};
                q_reg  <= {1'b0, q_reg[WIDTH-1:1]};
            end
        end
    end

    assign done   = done_reg;
    assign result = is_div_reg ? q_reg : acc_reg;

endmodule

`default_nettype wire

>>> design/rau_gcd.sv
// Binary gcd of two nonzero magnitudes, one shift or compare-subtract step per cycle.
`default_nettype none

module rau_gcd #(
    parameter int WIDTH = 32
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [WIDTH-1:0] u_in,
    input  logic [WIDTH-1:0] v_in,
    output logic             done,
    output logic [WIDTH-1:0] gcd
);
    import rau_pkg::*;

    localparam int CW = $clog2(WIDTH);

    logic             busy_reg;
    logic             done_reg;
    logic [CW-1:0]    k_reg;       // common power of two
    logic [WIDTH-1:0] u_reg;
    logic [WIDTH-1:0] v_reg;
    logic [WIDTH-1:0] g_reg;

    logic [WIDTH:0]   diff;
    logic             u_even;
    logic             v_even;
    logic             equal;

    // v - u decides swap, subtract or finish
    always_comb begin
        diff   = {1'b0, v_reg} - {1'b0, u_reg};
        u_even = ~u_reg[0];
        v_even = ~v_reg[0];
        equal  = (diff == '0);
    end

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            k_reg    <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                k_reg    <= '0;
            end else if (busy_reg) begin
                if (u_even && v_even) begin
                    k_reg <= k_reg + CW'(1);
                end else if (!u_even && !v_even && equal) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            u_reg <= u_in;
            v_reg <= v_in;
        end else if (busy_reg) begin
            if (u_even && v_even) begin
                u_reg <= {1'b0, u_reg[WIDTH-1:1]};
                v_reg <= {1'b0, v_reg[WIDTH-1:1]};
            end else if (u_even) begin
                u_reg <= {1'b0, u_reg[WIDTH-1:1]};
            end else if (v_even) begin
                v_reg <= {1'b0, v_reg[WIDTH-1:1]};
            end else if (equal) begin
                g_reg <= u_reg << k_reg;
            end else if (diff[WIDTH]) begin
                // u > v: swap so the next step subtracts the smaller one
                u_reg <= v_reg;
                v_reg <= u_reg;
            end else begin
                v_reg <= {1'b0, diff[WIDTH-1:1]};
            end
        end
    end

    assign done = done_reg;
    assign gcd  = g_reg;

endmodule

`default_nettype wire

>>> design/rational_arith_unit.sv
// Top level: rational multiply, add and simplify with an iterative sequencer.
//
// Input channel s_*: a request with s_req_type (0 multiply, 1 add, 2 simplify a)
// and two fractions a and b as signed numerator/denominator pairs.
// Output channel m_*: one fraction per request plus m_div_error, set when
// simplify sees a zero denominator. Results wrap to WIDTH bits.
// All products go through one shift-add unit, one bit per cycle:
//   multiply : two products in turn, add : three products in turn,
//   simplify : binary gcd plus two restoring divisions in the same shared
//              unit; zero numerator or denominator skips the gcd and the divisions.
// One request at a time: s_ready is high only while the sequencer is idle.
// The finished result sits in an output register; the next request is taken
// while it waits for m_ready. If a second result is done before the first is
// taken, the sequencer holds it until the output register frees.
// Reset (aresetn low, synchronous) empties the output register and returns
// the sequencer to idle.
`default_nettype none

module rational_arith_unit #(
    parameter int WIDTH = 32
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [1:0]              s_req_type,
    input  logic signed [WIDTH-1:0] s_a_num,
    input  logic signed [WIDTH-1:0] s_a_den,
    input  logic signed [WIDTH-1:0] s_b_num,
    input  logic signed [WIDTH-1:0] s_b_den,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [WIDTH-1:0] m_res_num,
    output logic signed [WIDTH-1:0] m_res_den,
    output logic                    m_div_error
);
    import rau_pkg::*;

    localparam logic [WIDTH-1:0] ONE = WIDTH'(1);

    state_t           state_reg;
    state_t           state_next;

    logic [1:0]       op_reg;
    logic [WIDTH-1:0] an_reg;
    logic [WIDTH-1:0] ad_reg;
    logic [WIDTH-1:0] bn_reg;
    logic [WIDTH-1:0] bd_reg;
    logic [WIDTH-1:0] mn_reg;
    logic [WIDTH-1:0] md_reg;
    logic [WIDTH-1:0] rn_reg;
    logic [WIDTH-1:0] rd_reg;
    logic             err_reg;

    logic             m_valid_reg;
    logic [WIDTH-1:0] m_num_reg;
    logic [WIDTH-1:0] m_den_reg;
    logic             m_err_reg;

    logic             accept;
    logic             out_free;
    logic             simp_special;
    logic [WIDTH-1:0] mag_an;
    logic [WIDTH-1:0] mag_ad;
    logic [WIDTH-1:0] quot_neg;

    alu_cmd_t         alu_cmd;
    logic [WIDTH-1:0] alu_x;
    logic [WIDTH-1:0] alu_y;
    logic             alu_done;
    logic [WIDTH-1:0] alu_result;

    logic             gcd_start;
    logic             gcd_done;
    logic [WIDTH-1:0] gcd_val;

    // Handshake and input magnitudes
    always_comb begin
        s_ready      = (state_reg == S_IDLE);
        accept       = s_valid && s_ready;
        out_free     = !m_valid_reg || m_ready;
        simp_special = (s_a_den == '0) || (s_a_num == '0);
        mag_an       = s_a_num[WIDTH-1] ? (~s_a_num + ONE) : s_a_num;
        mag_ad       = s_a_den[WIDTH-1] ? (~s_a_den + ONE) : s_a_den;
        quot_neg     = ~alu_result + ONE;
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    case (s_req_type)
                        REQ_MUL, REQ_ADD: state_next = S_MUL1;
                        REQ_SIMP:         state_next = simp_special ? S_OUT : S_GCD;
                        default:          state_next = S_OUT;
                    endcase
                end
            end
            S_MUL1: begin
                if (alu_done) begin
                    state_next = (op_reg == REQ_ADD) ? S_MUL2 : S_MUL3;
                end
            end
            S_MUL2:  if (alu_done) state_next = S_MUL3;
            S_MUL3:  if (alu_done) state_next = S_OUT;
            S_GCD:   if (gcd_done) state_next = S_DIV1;
            S_DIV1:  if (alu_done) state_next = S_DIV2;
            S_DIV2:  if (alu_done) state_next = S_OUT;
            S_OUT:   if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Unit commands, issued on the transition into each compute state
    always_comb begin
        alu_cmd.start = 1'b0;
        alu_cmd.op    = ALU_MUL;
        alu_x         = s_a_num;
        alu_y         = s_b_num;
        gcd_start     = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    case (s_req_type)
                        REQ_MUL: begin
                            alu_cmd.start = 1'b1;
                        end
                        REQ_ADD: begin
                            alu_cmd.start = 1'b1;
                            alu_y         = s_b_den;
                        end
                        REQ_SIMP: begin
                            gcd_start = !simp_special;
                        end
                        default: ;
                    endcase
                end
            end
            S_MUL1: begin
                alu_cmd.start = alu_done;
                alu_x         = (op_reg == REQ_ADD) ? bn_reg : ad_reg;
                alu_y         = (op_reg == REQ_ADD) ? ad_reg : bd_reg;
            end
            S_MUL2: begin
                alu_cmd.start = alu_done;
                alu_x         = ad_reg;
                alu_y         = bd_reg;
            end
            S_GCD: begin
                alu_cmd.start = gcd_done;
                alu_cmd.op    = ALU_DIV;
                alu_x         = mn_reg;
                alu_y         = gcd_val;
            end
            S_DIV1: begin
                alu_cmd.start = alu_done;
                alu_cmd.op    = ALU_DIV;
                alu_x         = md_reg;
                alu_y         = gcd_val;
            end
            default: ;
        endcase
    end

    // State and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Request capture and result assembly
    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    op_reg  <= s_req_type;
                    an_reg  <= s_a_num;
                    ad_reg  <= s_a_den;
                    bn_reg  <= s_b_num;
                    bd_reg  <= s_b_den;
                    mn_reg  <= mag_an;
                    md_reg  <= mag_ad;
                    rn_reg  <= '0;
                    rd_reg  <= '0;
                    err_reg <= 1'b0;
                    if (s_req_type == REQ_SIMP) begin
                        if (s_a_den == '0) begin
                            // zero denominator: pass through, flag it
                            rn_reg  <= s_a_num;
                            rd_reg  <= s_a_den;
                            err_reg <= 1'b1;
                        end else if (s_a_num == '0) begin
                            // zero numerator: 0 over the sign of the denominator
                            rd_reg <= s_a_den[WIDTH-1] ? '1 : ONE;
                        end
                    end
                end
            end
            S_MUL1:  if (alu_done) rn_reg <= alu_result;
            S_MUL2:  if (alu_done) rn_reg <= rn_reg + alu_result;
            S_MUL3:  if (alu_done) rd_reg <= alu_result;
            S_DIV1:  if (alu_done) rn_reg <= an_reg[WIDTH-1] ? quot_neg : alu_result;
            S_DIV2:  if (alu_done) rd_reg <= ad_reg[WIDTH-1] ? quot_neg : alu_result;
            S_OUT: begin
                if (out_free) begin
                    m_num_reg <= rn_reg;
                    m_den_reg <= rd_reg;
                    m_err_reg <= err_reg;
                end
            end
            default: ;
        endcase
    end

    rau_alu #(
        .WIDTH (WIDTH)
    ) u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (alu_cmd),
        .opx     (alu_x),
        .opy     (alu_y),
        .done    (alu_done),
        .result  (alu_result)
    );

    rau_gcd #(
        .WIDTH (WIDTH)
    ) u_gcd (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (gcd_start),
        .u_in    (mag_an),
        .v_in    (mag_ad),
        .done    (gcd_done),
        .gcd     (gcd_val)
    );

    assign m_valid     = m_valid_reg;
    assign m_res_num   = m_num_reg;
    assign m_res_den   = m_den_reg;
    assign m_div_error = m_err_reg;

endmodule

`default_nettype wire
